// ===== src/tcce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ADDR_W  = 11;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int COLOR_W = 4;
  localparam int CELL_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam int                TAB_STEP = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG   = 2'd3;

  // Reset values
  localparam logic [COL_W-1:0]   RST_COLS = 7'd80;
  localparam logic [ROW_W-1:0]   RST_ROWS = 5'd25;
  localparam logic [COLOR_W-1:0] RST_FG   = 4'd15;
  localparam logic [COLOR_W-1:0] RST_BG   = 4'd0;
  localparam logic [CELL_W-1:0]  RST_CELL = 16'h0F20;

  // Effective geometry and colors
  typedef struct packed {
    logic [COL_W-1:0]   cols;
    logic [ROW_W-1:0]   rows;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } tcce_geom_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
  } tcce_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } tcce_result_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg,
                                                  input logic [CHAR_W-1:0] ch);
    return {bg, fg, ch};
  endfunction

endpackage

`default_nettype wire

// ===== src/tcce_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcce_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tcce_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcce_seq #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tcce_pkg::tcce_geom_t  geom,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire tcce_pkg::tcce_item_t  in_item,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output tcce_pkg::tcce_result_t     out_res
);

  import tcce_pkg::*;

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  // Index width: covers the memory and the row-times-column products
  localparam int IW = (AW > ROW_W + COL_W + 1) ? AW : ROW_W + COL_W + 1;
  localparam int PW = ROW_W + COL_W;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_BLANK  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  tcce_item_t          item_r, item_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [CELL_W-1:0]   value_r, value_nxt;
  logic                scrolled_r, scrolled_nxt;
  logic [IW-1:0]       area_r, area_nxt;
  logic [IW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [IW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcce_result_t        out_res_r, out_res_nxt;

  logic                mem_we, mem_re;
  logic [IW-1:0]       wr_idx, rd_idx;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;

  logic [PW-1:0]       row_prod;
  logic [PW-1:0]       area_prod;
  logic [IW-1:0]       put_idx;
  logic [COL_W:0]      col_inc, col_tab;
  logic                line_brk;
  logic                at_bottom;
  logic [CELL_W-1:0]   blank_cell;
  logic [IW-1:0]       addr_ext;
  logic                addr_ok;

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wr_idx[AW-1:0]),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(rd_idx[AW-1:0]),
    .rdata(mem_rdata)
  );

  // Address and cursor arithmetic
  assign row_prod   = PW'(row_r) * PW'(geom.cols);
  assign area_prod  = PW'(geom.rows) * PW'(geom.cols);
  assign put_idx    = IW'(row_prod) + IW'(col_r);
  assign col_inc    = {1'b0, col_r} + (COL_W+1)'(1);
  assign col_tab    = {1'b0, col_r} + (COL_W+1)'(TAB_STEP);
  assign at_bottom  = ({1'b0, row_r} + (ROW_W+1)'(1)) >= {1'b0, geom.rows};
  assign blank_cell = make_cell(geom.fg, geom.bg, CH_SPACE);
  assign addr_ext   = IW'(item_r.cell_address);
  assign addr_ok    = 32'(item_r.cell_address) < 32'(CELL_COUNT);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    value_nxt     = value_r;
    scrolled_nxt  = scrolled_r;
    area_nxt      = area_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    wr_idx        = wr_ptr_r;
    rd_idx        = rd_ptr_r;
    mem_wdata     = blank_cell;
    line_brk      = 1'b0;
    in_tready     = 1'b0;

    unique case (state_r)
      S_INIT: begin
        // Sweep the whole store to the reset cell
        mem_we    = 1'b1;
        mem_wdata = RST_CELL;
        if (wr_ptr_r == IW'(CELL_COUNT - 1)) begin
          wr_ptr_nxt = '0;
          state_nxt  = S_IDLE;
        end else begin
          wr_ptr_nxt = wr_ptr_r + IW'(1);
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          item_nxt     = in_item;
          value_nxt    = '0;
          scrolled_nxt = 1'b0;
          area_nxt     = IW'(area_prod);
          // Pull the cursor back inside a shrunken screen
          if (in_item.opcode == OP_PUT) begin
            if (row_r >= geom.rows) row_nxt = geom.rows - ROW_W'(1);
            if (col_r >= geom.cols) col_nxt = geom.cols - COL_W'(1);
          end
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (item_r.opcode)
          OP_PUT: begin
            if (item_r.char_code == CH_NL) begin
              line_brk = 1'b1;
            end else if (item_r.char_code == CH_TAB) begin
              if (col_tab >= {1'b0, geom.cols}) line_brk = 1'b1;
              else col_nxt = col_tab[COL_W-1:0];
            end else if (item_r.char_code == CH_CR) begin
              col_nxt = '0;
            end else begin
              mem_we    = 1'b1;
              wr_idx    = put_idx;
              mem_wdata = make_cell(geom.fg, geom.bg, item_r.char_code);
              if (col_inc >= {1'b0, geom.cols}) line_brk = 1'b1;
              else col_nxt = col_inc[COL_W-1:0];
            end
            state_nxt = S_DONE;
            if (line_brk) begin
              col_nxt = '0;
              if (at_bottom) begin
                // Scroll: copy rows up, then blank the last row
                scrolled_nxt = 1'b1;
                row_nxt      = geom.rows - ROW_W'(1);
                rd_ptr_nxt   = IW'(geom.cols);
                wr_ptr_nxt   = '0;
                state_nxt    = S_SCROLL;
              end else begin
                row_nxt = row_r + ROW_W'(1);
              end
            end
          end
          OP_CLEAR: begin
            row_nxt    = '0;
            col_nxt    = '0;
            wr_ptr_nxt = '0;
            state_nxt  = S_BLANK;
          end
          OP_READ: begin
            if (addr_ok) begin
              mem_re    = 1'b1;
              rd_idx    = addr_ext;
              state_nxt = S_RDWAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDWAIT: begin
        value_nxt = mem_rdata;
        state_nxt = S_DONE;
      end
      S_SCROLL: begin
        // Read one row ahead, write the beat returned last cycle
        if (rd_ptr_r < area_r) begin
          mem_re     = 1'b1;
          rd_ptr_nxt = rd_ptr_r + IW'(1);
          pend_nxt   = 1'b1;
        end
        if (pend_r) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata;
          wr_ptr_nxt = wr_ptr_r + IW'(1);
        end
        if (!(rd_ptr_r < area_r) && !pend_r) state_nxt = S_BLANK;
      end
      S_BLANK: begin
        if (wr_ptr_r < area_r) begin
          mem_we     = 1'b1;
          wr_ptr_nxt = wr_ptr_r + IW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{cursor_row: row_r, cursor_col: col_r,
                            cell_value: value_r, scrolled: scrolled_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      row_r       <= '0;
      col_r       <= '0;
      wr_ptr_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    value_r    <= value_nxt;
    scrolled_r <= scrolled_nxt;
    area_r     <= area_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  // Writes outside the reset sweep stay inside the visible screen
  a_write_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_INIT) |-> (wr_idx < area_r))
    else $error("cell write beyond visible screen");

  // Scroll copy never reads and writes the same cell in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (wr_idx != rd_idx))
    else $error("read and write to the same cell");

  // A scroll leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && scrolled_r) |->
      (row_r == geom.rows - ROW_W'(1) && col_r == '0))
    else $error("cursor not on last row after scroll");

  // The store is only read in the execute and scroll states
  a_read_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (state_r == S_EXEC || state_r == S_SCROLL))
    else $error("unexpected memory read");

endmodule

`default_nettype wire

// ===== src/text_console_cursor_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console engine: a MAX_COLS x MAX_ROWS store of 16-bit cells
// ({background, foreground, character}) and a cursor. After reset the block
// sweeps the whole store to blank cells, one cell per cycle, and takes no
// item during that time; config writes are taken at any time. Items then
// run one at a time through a sequencer built around a single-write-port
// memory: a clear blanks rows*cols cells, and a put that scrolls copies the
// rows up and blanks the last row, one cell copied or blanked per cycle.
// The result sits in an output register, so the next item is accepted
// while it waits.

module text_console_cursor_engine_top #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tdata: opcode[1:0], char_code[9:2], cell_address[20:10]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // tdata: cursor_row[4:0], cursor_col[11:5], cell_value[27:12], scrolled[28]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tcce_pkg::*;

  localparam logic [COL_W+1:0] MAX_COLS_W = (COL_W+2)'(MAX_COLS);
  localparam logic [ROW_W+2:0] MAX_ROWS_W = (ROW_W+3)'(MAX_ROWS);

  logic [COL_W-1:0]   cols_r;
  logic [ROW_W-1:0]   rows_r;
  logic [COLOR_W-1:0] fg_r;
  logic [COLOR_W-1:0] bg_r;
  tcce_geom_t         geom;
  tcce_item_t         item;
  tcce_result_t       res;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= RST_COLS;
      rows_r <= RST_ROWS;
      fg_r   <= RST_FG;
      bg_r   <= RST_BG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COLS: cols_r <= cfg_data[COL_W-1:0];
        REG_ROWS: rows_r <= cfg_data[ROW_W-1:0];
        REG_FG:   fg_r   <= cfg_data[COLOR_W-1:0];
        REG_BG:   bg_r   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to 1..max
  always_comb begin
    if (cols_r == '0) geom.cols = COL_W'(1);
    else if ((COL_W+2)'(cols_r) > MAX_COLS_W) geom.cols = COL_W'(MAX_COLS);
    else geom.cols = cols_r;
    if (rows_r == '0) geom.rows = ROW_W'(1);
    else if ((ROW_W+3)'(rows_r) > MAX_ROWS_W) geom.rows = ROW_W'(MAX_ROWS);
    else geom.rows = rows_r;
    geom.fg = fg_r;
    geom.bg = bg_r;
  end

  // Unpack the input beat
  assign item.opcode       = in_tdata[1:0];
  assign item.char_code    = in_tdata[9:2];
  assign item.cell_address = in_tdata[20:10];

  tcce_seq #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (item),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_res   (res)
  );

  // Pack the result beat
  assign out_tdata = {3'b000, res.scrolled, res.cell_value, res.cursor_col, res.cursor_row};

endmodule

`default_nettype wire
